// File: sv/msw_pkg.sv
// ----------------------------------------------------------------------------
// msw_pkg: shared types and constants for point_set_mst_weight
// Sizes of the point store, coordinate and weight widths, sequencer states.
// ----------------------------------------------------------------------------
package msw_pkg;

  localparam int MaxPoints = 64;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int CoordW    = 16;
  // squared distance: two squares of a CoordW-bit magnitude, plus a carry
  localparam int SqW       = 2 * CoordW + 1;
  localparam int WeightW   = 39;
  localparam int InDataW   = 2 * CoordW;
  localparam int OutDataW  = ((WeightW + 7) / 8) * 8;

  typedef enum logic [3:0] {
    ST_LOAD,   // taking points
    ST_FETCH,  // read the newly added tree node
    ST_CUR,    // latch its coordinates, close the round
    ST_RD,     // read point j and its best distance
    ST_DIFF,   // coordinate differences, start squaring
    ST_SQ,     // wait for the square unit
    ST_UPD,    // update distance, track minimum
    ST_ADV,    // next j or end of round
    ST_OUT     // hand the result to the output register
  } msw_state_e;

endpackage

// File: sv/msw_sqdist.sv
// ----------------------------------------------------------------------------
// msw_sqdist: squared distance unit
// One shared multiplier squares dx, then dy, and sums them in the accumulator.
// ----------------------------------------------------------------------------
module msw_sqdist (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [msw_pkg::CoordW-1:0] ax_i,
  input  logic [msw_pkg::CoordW-1:0] ay_i,
  output logic                       done_o,
  output logic [msw_pkg::SqW-1:0]    dist_o
);
  import msw_pkg::*;

  logic                  second_q, done_q;
  logic [CoordW-1:0]     ay_q, mul_op;
  logic [2*CoordW-1:0]   product;
  logic [SqW-1:0]        acc_q;

  // single squaring multiplier, operand picked by phase
  assign mul_op  = second_q ? ay_q : ax_i;
  assign product = mul_op * mul_op;

  // phase control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      second_q <= start_i;
      done_q   <= second_q;
    end
  end

  // accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= SqW'(product);
      ay_q  <= ay_i;
    end else if (second_q) begin
      acc_q <= acc_q + SqW'(product);
    end
  end

  assign done_o = done_q;
  assign dist_o = acc_q;

endmodule

// File: sv/point_set_mst_weight.sv
// ----------------------------------------------------------------------------
// point_set_mst_weight: minimum spanning tree weight of a 2-D point set
// Loads points, then grows a tree node by node with one shared square unit.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one point per item: tdata = {y, x}, tlast marks the
//   last point of a set. Points past 64 are dropped and flagged.
//   Master stream carries one result per set: tdata = total weight (sum of
//   squared edge lengths), tuser = overflow.
//   Loading accepts one point per cycle. After the last point the tree is
//   grown one node per round; each round sweeps all N stored points, and a
//   point not yet in the tree passes through the square unit and update
//   path, while one that has joined skips them; a single point gives 0 at once.
//   s_axis_tready is high only while loading. The result sits in an output
//   register; while the receiver stalls, the next set may already load, and
//   its result waits until the register frees.
//   Reset clears the point count, overflow flag and output valid; the point
//   and distance memories need no clearing.
// ----------------------------------------------------------------------------
module point_set_mst_weight (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [msw_pkg::InDataW-1:0]  s_axis_tdata_i,   // point_x, point_y
  input  logic                         s_axis_tlast_i,   // last_point
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [msw_pkg::OutDataW-1:0] m_axis_tdata_o,   // total_weight, zero pad
  output logic                         m_axis_tuser_o    // overflow
);
  import msw_pkg::*;

  msw_state_e state_q, state_d;

  logic [InDataW-1:0]   pts_mem [MaxPoints];
  logic [SqW-1:0]       dist_mem [MaxPoints];
  logic [InDataW-1:0]   pt_rd_q;
  logic [SqW-1:0]       dist_rd_q;
  logic [IdxW-1:0]      rd_addr;

  logic [CntW-1:0]      cnt_q, added_q;
  logic                 ovf_q, first_q, best_ok_q, sq_go_q;
  logic [IdxW-1:0]      j_q, bj_q;
  logic [MaxPoints-1:0] in_tree_q;
  logic [CoordW-1:0]    cx_q, cy_q, ax_q, ay_q;
  logic [SqW-1:0]       best_q, newd;
  logic [WeightW-1:0]   total_q;
  logic                 out_valid_q, out_ovf_q;
  logic [WeightW-1:0]   out_w_q;

  logic s_acc, m_free, load_last, j_last, sq_start, sq_done, round_end;
  logic [SqW-1:0]       sq_dist;
  logic [CntW-1:0]      n_after;
  logic signed [CoordW:0] dx, dy;

  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign m_free    = !out_valid_q || m_axis_tready_i;
  assign load_last = s_acc && s_axis_tlast_i;
  assign n_after   = (cnt_q < CntW'(MaxPoints)) ? cnt_q + 1'b1 : cnt_q;
  assign j_last    = ({1'b0, j_q} == cnt_q - 1'b1);
  assign round_end = (added_q + 1'b1 == cnt_q);

  // coordinate differences against the current tree node
  assign dx = $signed({pt_rd_q[CoordW-1], pt_rd_q[CoordW-1:0]})
            - $signed({cx_q[CoordW-1], cx_q});
  assign dy = $signed({pt_rd_q[InDataW-1], pt_rd_q[InDataW-1:CoordW]})
            - $signed({cy_q[CoordW-1], cy_q});

  // candidate distance: first round takes the fresh one, later rounds the smaller
  assign newd = (first_q || sq_dist < dist_rd_q) ? sq_dist : dist_rd_q;

  msw_sqdist u_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .ax_i    (ax_q),
    .ay_i    (ay_q),
    .done_o  (sq_done),
    .dist_o  (sq_dist)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:  if (load_last) state_d = (n_after > CntW'(1)) ? ST_FETCH : ST_OUT;
      ST_FETCH: state_d = ST_CUR;
      ST_CUR:   state_d = round_end ? ST_OUT : ST_RD;
      ST_RD:    state_d = ST_DIFF;
      ST_DIFF:  state_d = in_tree_q[j_q] ? ST_ADV : ST_SQ;
      ST_SQ:    if (sq_done) state_d = ST_UPD;
      ST_UPD:   state_d = ST_ADV;
      ST_ADV:   state_d = j_last ? ST_FETCH : ST_RD;
      ST_OUT:   if (m_free) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  // outputs of the sequencer; squaring starts once the magnitudes are latched
  always_comb begin
    s_axis_tready_o = (state_q == ST_LOAD);
    rd_addr         = (state_q == ST_FETCH) ? bj_q : j_q;
    sq_start        = sq_go_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_LOAD;
    else         state_q <= state_d;
  end

  // memories: registered reads
  always_ff @(posedge clk_i) begin
    if (s_acc && cnt_q < CntW'(MaxPoints)) pts_mem[cnt_q[IdxW-1:0]] <= s_axis_tdata_i;
    if (state_q == ST_UPD) dist_mem[j_q] <= newd;
    pt_rd_q   <= pts_mem[rd_addr];
    dist_rd_q <= dist_mem[rd_addr];
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && m_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      added_q     <= '0;
      first_q     <= 1'b1;
      best_ok_q   <= 1'b0;
      sq_go_q     <= 1'b0;
      j_q         <= '0;
      bj_q        <= '0;
      in_tree_q   <= '0;
    end else begin
      sq_go_q <= (state_q == ST_DIFF) && !in_tree_q[j_q];
      case (state_q)
        ST_LOAD: if (s_acc) begin
          cnt_q <= n_after;
          if (cnt_q == CntW'(MaxPoints)) ovf_q <= 1'b1;
          added_q   <= '0;
          bj_q      <= '0;
          j_q       <= '0;
          best_ok_q <= 1'b0;
          in_tree_q <= '0;
        end
        ST_CUR: begin
          in_tree_q[bj_q] <= 1'b1;
          added_q         <= added_q + 1'b1;
          first_q         <= (added_q == '0);
          best_ok_q       <= 1'b0;
          j_q             <= '0;
        end
        ST_UPD: if (!best_ok_q || newd < best_q) begin
          best_ok_q <= 1'b1;
          bj_q      <= j_q;
        end
        ST_ADV: if (!j_last) j_q <= j_q + 1'b1;
        ST_OUT: if (m_free) begin
          cnt_q       <= '0;
          ovf_q       <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: if (s_acc) begin
        total_q <= '0;
        best_q  <= '0;
      end
      ST_CUR: begin
        cx_q    <= pt_rd_q[CoordW-1:0];
        cy_q    <= pt_rd_q[InDataW-1:CoordW];
        total_q <= total_q + WeightW'(best_q);
      end
      ST_DIFF: begin
        ax_q <= dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
        ay_q <= dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
      end
      ST_UPD: if (!best_ok_q || newd < best_q) best_q <= newd;
      ST_OUT: if (m_free) begin
        out_w_q   <= total_q;
        out_ovf_q <= ovf_q;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'(out_w_q);
  assign m_axis_tuser_o  = out_ovf_q;

endmodule

// File: sv/msw_checker.sv
// ----------------------------------------------------------------------------
// msw_checker: port-level checks for point_set_mst_weight
// Watches the load handshake and the result register over time.
// ----------------------------------------------------------------------------
module msw_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         s_axis_tlast_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [msw_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                         m_axis_tuser_o
);
  import msw_pkg::*;

  // a last point ends loading
  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("ready after last point");

  // loading goes on after an ordinary point
  a_load_goes_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tlast_i |=> s_axis_tready_o)
    else $error("loading stopped early");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

endmodule

bind point_set_mst_weight msw_checker u_msw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
